/* src/biq_pkg.sv */
// Shared types, constants and register map of the biquad filter block.
// No dependencies; compile first.
package biq_pkg;

    localparam int SAMPLE_W        = 8;
    localparam int GAIN_W          = 16;
    localparam int COEF_W          = 16;
    localparam int XN_W            = SAMPLE_W + GAIN_W;
    localparam int FB_FRAC         = 14;
    localparam int CHUNK_W         = 16;
    localparam int MAG_W           = 33;
    localparam int MUL_A_W         = COEF_W + 1;
    localparam int MUL_B_W         = MAG_W + 1;
    localparam int PROD_W          = MUL_A_W + MUL_B_W;
    localparam int OUT_SHIFT       = 24;
    localparam int STATE_WIDTH_DEF = 40;

    localparam int APB_DATA_W      = 32;
    localparam int PADDR_W         = 5;
    localparam int REG_IDX_W       = PADDR_W - 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_INVERSE_GAIN = 3'd0;
    localparam reg_idx_t REG_OUTPUT_GAIN  = 3'd1;
    localparam reg_idx_t REG_FEEDBACK_ONE = 3'd2;
    localparam reg_idx_t REG_FEEDBACK_TWO = 3'd3;
    localparam reg_idx_t REG_LOWPASS_MODE = 3'd4;

    localparam logic [GAIN_W-1:0] INVERSE_GAIN_RST = 16'd61996;
    localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST  = 16'd271;
    localparam logic [COEF_W-1:0] FEEDBACK_ONE_RST = 16'd30950;
    localparam logic [COEF_W-1:0] FEEDBACK_TWO_RST = 16'd50874;

    typedef struct packed {
        logic [GAIN_W-1:0] inverse_gain;
        logic [GAIN_W-1:0] output_gain;
        logic [COEF_W-1:0] feedback_one;
        logic [COEF_W-1:0] feedback_two;
        logic              lowpass_mode;
    } biq_cfg_t;

    typedef struct packed {
        logic capture;
        logic calc_xn;
        logic load_pre;
        logic fb_run;
        logic update;
        logic out_mul;
        logic emit;
    } biq_cmd_t;

    typedef struct packed {
        logic fb_done;
        logic out_free;
    } biq_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XN,
        ST_PRE,
        ST_FB,
        ST_UPD,
        ST_OMUL,
        ST_RES
    } biq_state_t;

endpackage

/* src/biq_in_if.sv */
// Input channel of the biquad filter: one sample per transfer.
// Depends on biq_pkg.
interface biq_in_if;
    logic                          valid;
    logic                          ready;
    logic [biq_pkg::SAMPLE_W-1:0]  sample_in;
    logic                          start_of_block;

    modport source (output valid, output sample_in, output start_of_block, input ready);
    modport sink (input valid, input sample_in, input start_of_block, output ready);
endinterface

/* src/biq_out_if.sv */
// Result channel of the biquad filter: one filtered sample per transfer.
// Depends on biq_pkg.
interface biq_out_if;
    logic                          valid;
    logic                          ready;
    logic [biq_pkg::SAMPLE_W-1:0]  sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

/* src/biq_cfg.sv */
// APB register bank holding the filter gains, coefficients and mode.
// Depends on biq_pkg.
module biq_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [biq_pkg::PADDR_W-1:0]        paddr,
    input  logic [biq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [biq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output biq_pkg::biq_cfg_t                  cfg
);

    biq_pkg::biq_cfg_t cfg_reg;
    biq_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = paddr[biq_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inverse_gain <= biq_pkg::INVERSE_GAIN_RST;
            cfg_reg.output_gain  <= biq_pkg::OUTPUT_GAIN_RST;
            cfg_reg.feedback_one <= biq_pkg::FEEDBACK_ONE_RST;
            cfg_reg.feedback_two <= biq_pkg::FEEDBACK_TWO_RST;
            cfg_reg.lowpass_mode <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                biq_pkg::REG_INVERSE_GAIN: cfg_reg.inverse_gain <= pwdata[biq_pkg::GAIN_W-1:0];
                biq_pkg::REG_OUTPUT_GAIN:  cfg_reg.output_gain  <= pwdata[biq_pkg::GAIN_W-1:0];
                biq_pkg::REG_FEEDBACK_ONE: cfg_reg.feedback_one <= pwdata[biq_pkg::COEF_W-1:0];
                biq_pkg::REG_FEEDBACK_TWO: cfg_reg.feedback_two <= pwdata[biq_pkg::COEF_W-1:0];
                biq_pkg::REG_LOWPASS_MODE: cfg_reg.lowpass_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            biq_pkg::REG_INVERSE_GAIN: prdata[biq_pkg::GAIN_W-1:0] = cfg_reg.inverse_gain;
            biq_pkg::REG_OUTPUT_GAIN:  prdata[biq_pkg::GAIN_W-1:0] = cfg_reg.output_gain;
            biq_pkg::REG_FEEDBACK_ONE: prdata[biq_pkg::COEF_W-1:0] = cfg_reg.feedback_one;
            biq_pkg::REG_FEEDBACK_TWO: prdata[biq_pkg::COEF_W-1:0] = cfg_reg.feedback_two;
            biq_pkg::REG_LOWPASS_MODE: prdata[0] = cfg_reg.lowpass_mode;
            default: prdata = '0;
        endcase
    end

endmodule

/* src/biq_ctrl.sv */
// Sequencing state machine of the biquad filter.
// Depends on biq_pkg; drives the datapath in biq_dp through command signals.
module biq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  biq_pkg::biq_status_t  status,
    output biq_pkg::biq_cmd_t     cmd
);

    biq_pkg::biq_state_t state_reg;
    biq_pkg::biq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= biq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            biq_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = biq_pkg::ST_XN;
                end
            end
            biq_pkg::ST_XN:   state_next = biq_pkg::ST_PRE;
            biq_pkg::ST_PRE:  state_next = biq_pkg::ST_FB;
            biq_pkg::ST_FB:
            begin
                if (status.fb_done)
                begin
                    state_next = biq_pkg::ST_UPD;
                end
            end
            biq_pkg::ST_UPD:  state_next = biq_pkg::ST_OMUL;
            biq_pkg::ST_OMUL: state_next = biq_pkg::ST_RES;
            biq_pkg::ST_RES:
            begin
                if (status.out_free)
                begin
                    state_next = biq_pkg::ST_IDLE;
                end
            end
            default: state_next = biq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            biq_pkg::ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            biq_pkg::ST_XN:   cmd.calc_xn  = 1'b1;
            biq_pkg::ST_PRE:  cmd.load_pre = 1'b1;
            biq_pkg::ST_FB:   cmd.fb_run   = 1'b1;
            biq_pkg::ST_UPD:  cmd.update   = 1'b1;
            biq_pkg::ST_OMUL: cmd.out_mul  = 1'b1;
            biq_pkg::ST_RES:  cmd.emit     = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* src/biq_dp.sv */
// Datapath of the biquad filter: history, shared multiplier, accumulator
// and output register. Depends on biq_pkg; commanded by biq_ctrl.
module biq_dp #(
    parameter int STATE_WIDTH = biq_pkg::STATE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  biq_pkg::biq_cfg_t             cfg,
    input  biq_pkg::biq_cmd_t             cmd,
    output biq_pkg::biq_status_t          status,
    input  logic [biq_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                          start_of_block,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [biq_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                          clipped
);

    localparam int AW     = STATE_WIDTH + biq_pkg::FB_FRAC;
    localparam int NCH    = (AW + biq_pkg::CHUNK_W - 1) / biq_pkg::CHUNK_W;
    localparam int YX_W   = NCH * biq_pkg::CHUNK_W;
    localparam int STEP_W = $clog2(2 * NCH + 1);
    localparam int CH_W   = $clog2(NCH);
    localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(2 * NCH);
    localparam logic [STATE_WIDTH:0] MAG_CAP   = (STATE_WIDTH + 1)'(1) << 32;
    localparam int PROD_INT_W = biq_pkg::MAG_W + biq_pkg::GAIN_W - biq_pkg::OUT_SHIFT;

    logic [biq_pkg::SAMPLE_W-1:0]      sample_reg;
    logic [biq_pkg::XN_W-1:0]          xn_reg;
    logic [STATE_WIDTH-1:0]            x1_reg;
    logic [STATE_WIDTH-1:0]            x2_reg;
    logic [STATE_WIDTH-1:0]            y1_reg;
    logic [STATE_WIDTH-1:0]            y2_reg;
    logic [AW-1:0]                     acc_reg;
    logic [STEP_W-1:0]                 step_reg;
    logic                              pvalid_reg;
    logic [CH_W-1:0]                   pchunk_reg;
    logic signed [biq_pkg::PROD_W-1:0] prod_reg;
    logic [biq_pkg::MAG_W-1:0]         mag_reg;
    logic                              neg_reg;
    logic                              out_valid_reg;
    logic [biq_pkg::SAMPLE_W-1:0]      out_sample_reg;
    logic                              out_clip_reg;

    logic [STATE_WIDTH-1:0]             xn_ext;
    logic [STATE_WIDTH-1:0]             x1_dbl;
    logic [STATE_WIDTH-1:0]             pre;
    logic                               cur_term;
    logic [CH_W-1:0]                    cur_chunk;
    logic [STATE_WIDTH-1:0]             y_sel;
    logic [biq_pkg::COEF_W-1:0]         c_sel;
    logic [YX_W-1:0]                    y_ext;
    logic [biq_pkg::CHUNK_W-1:0]        chunk;
    logic signed [biq_pkg::MUL_A_W-1:0] mul_a;
    logic signed [biq_pkg::MUL_B_W-1:0] mul_b;
    logic                               mul_fire;
    logic [AW-1:0]                      prod_ext;
    logic [AW-1:0]                      term;
    logic [STATE_WIDTH-1:0]             y_new;
    logic [STATE_WIDTH-1:0]             y_mag;
    logic [STATE_WIDTH:0]               mag_ext;
    logic [PROD_INT_W-1:0]              int_part;

    assign xn_ext = {{(STATE_WIDTH - biq_pkg::XN_W){1'b0}}, xn_reg};
    assign x1_dbl = {x1_reg[STATE_WIDTH-2:0], 1'b0};
    assign pre    = cfg.lowpass_mode ? (xn_ext + x2_reg + x1_dbl) : (xn_ext + x2_reg - x1_dbl);

    assign cur_term  = step_reg[0];
    assign cur_chunk = step_reg[CH_W:1];
    assign y_sel     = cur_term ? y2_reg : y1_reg;
    assign c_sel     = cur_term ? cfg.feedback_two : cfg.feedback_one;
    assign y_ext     = {{(YX_W - STATE_WIDTH){y_sel[STATE_WIDTH-1]}}, y_sel};
    assign chunk     = y_ext[cur_chunk * biq_pkg::CHUNK_W +: biq_pkg::CHUNK_W];

    assign mul_a = cmd.out_mul ? {1'b0, cfg.output_gain} : {c_sel[biq_pkg::COEF_W-1], c_sel};
    assign mul_b = cmd.out_mul ? {1'b0, mag_reg}
                               : {{(biq_pkg::MUL_B_W - biq_pkg::CHUNK_W){1'b0}}, chunk};
    assign mul_fire = cmd.out_mul || (cmd.fb_run && (step_reg != LAST_STEP));

    assign prod_ext = {{(AW - biq_pkg::MAG_W){prod_reg[biq_pkg::MAG_W-1]}},
                       prod_reg[biq_pkg::MAG_W-1:0]};
    assign term     = prod_ext << {pchunk_reg, 4'b0000};

    assign y_new   = acc_reg[AW-1:biq_pkg::FB_FRAC];
    assign y_mag   = y_new[STATE_WIDTH-1] ? (~y_new + 1'b1) : y_new;
    assign mag_ext = {1'b0, y_mag};

    assign int_part = prod_reg[biq_pkg::MAG_W + biq_pkg::GAIN_W - 1:biq_pkg::OUT_SHIFT];

    assign status.fb_done  = (step_reg == LAST_STEP);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign clipped    = out_clip_reg;

    // history and sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg        <= '0;
            x2_reg        <= '0;
            y1_reg        <= '0;
            y2_reg        <= '0;
            step_reg      <= '0;
            pvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture && start_of_block)
            begin
                x1_reg <= '0;
                x2_reg <= '0;
                y1_reg <= '0;
                y2_reg <= '0;
            end
            else if (cmd.update)
            begin
                x2_reg <= x1_reg;
                x1_reg <= xn_ext;
                y2_reg <= y1_reg;
                y1_reg <= y_new;
            end

            if (cmd.load_pre)
            begin
                step_reg   <= '0;
                pvalid_reg <= 1'b0;
            end
            else if (cmd.fb_run)
            begin
                pvalid_reg <= (step_reg != LAST_STEP);
                if (step_reg != LAST_STEP)
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample_in;
        end

        if (cmd.calc_xn)
        begin
            xn_reg <= sample_reg * cfg.inverse_gain;
        end

        if (cmd.load_pre)
        begin
            acc_reg <= {pre, {biq_pkg::FB_FRAC{1'b0}}};
        end
        else if (cmd.fb_run && pvalid_reg)
        begin
            acc_reg <= acc_reg + term;
        end

        if (mul_fire)
        begin
            prod_reg   <= mul_a * mul_b;
            pchunk_reg <= cur_chunk;
        end

        if (cmd.update)
        begin
            neg_reg <= y_new[STATE_WIDTH-1];
            mag_reg <= (mag_ext > MAG_CAP) ? MAG_CAP[biq_pkg::MAG_W-1:0]
                                           : mag_ext[biq_pkg::MAG_W-1:0];
        end

        if (cmd.emit)
        begin
            if (neg_reg)
            begin
                out_sample_reg <= '0;
                out_clip_reg   <= (int_part != '0);
            end
            else if (int_part > PROD_INT_W'(255))
            begin
                out_sample_reg <= '1;
                out_clip_reg   <= 1'b1;
            end
            else
            begin
                out_sample_reg <= int_part[biq_pkg::SAMPLE_W-1:0];
                out_clip_reg   <= 1'b0;
            end
        end
    end

endmodule

/* src/second_order_iir_biquad_top.sv */
// Second-order IIR biquad on unsigned 8-bit samples: one result per input transfer.
// A new input is not accepted until the previous sample is finished, since the single
// shared 17x34 multiplier forms the feedback partial products 16 bits of history at a
// time and then the output scaling. The result sits in an output register, so the next
// sample is taken while a finished result still waits. Write the gains, coefficients
// and mode through the APB port only while the filter is idle.
// Depends on biq_pkg, biq_in_if, biq_out_if, biq_cfg, biq_ctrl and biq_dp.
module second_order_iir_biquad_top #(
    parameter int STATE_WIDTH = biq_pkg::STATE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    biq_in_if.sink                          item,
    biq_out_if.source                       result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [biq_pkg::PADDR_W-1:0]     paddr,
    input  logic [biq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [biq_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    biq_pkg::biq_cfg_t    cfg;
    biq_pkg::biq_cmd_t    cmd;
    biq_pkg::biq_status_t status;

    biq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    biq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    biq_dp #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .status         (status),
        .sample_in      (item.sample_in),
        .start_of_block (item.start_of_block),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .sample_out     (result.sample_out),
        .clipped        (result.clipped)
    );

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("input taken while a sample is in progress");

    a_clip_only_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.sample_out != 8'd0) && (result.sample_out != 8'd255)
        |-> !result.clipped)
        else $error("clip flag set on an unsaturated sample");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> !$past(item.ready))
        else $error("result raised without a sample in progress");

endmodule
